### rtl/lsac_pkg.sv
package lsac_pkg;

    // Geometry of the line store
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_SETS     = 1 << MAX_SET_BITS;
    localparam int WAY_W        = $clog2(MAX_WAYS);
    localparam int LINE_AW      = MAX_SET_BITS + WAY_W;
    localparam int TAG_W        = 32;
    localparam int RANK_W       = 3;
    localparam int SUM_W        = 32;

    // Oldest rank a line can carry; ranks stop there
    localparam logic [RANK_W-1:0] RANK_MAX = '1;

    // Access kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_MODIFY = 2'd2;
    localparam logic [1:0] KIND_IFETCH = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WAYS   = 2'd2;

    // Configuration values after reset
    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [3:0] NUM_WAYS_RST   = 4'd1;

    typedef struct packed {
        logic [1:0]  access_kind;
        logic [31:0] address;
    } lsac_in_t;

    typedef struct packed {
        logic [1:0]       hit_count;
        logic             was_miss;
        logic             was_eviction;
        logic [SUM_W-1:0] total_hits;
        logic [SUM_W-1:0] total_misses;
        logic [SUM_W-1:0] total_evictions;
    } lsac_out_t;

    // Per-set replacement state: valid bits and LRU ranks of all ways
    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
    } lsac_row_t;

    // Control for one LRU update of a set row
    typedef struct packed {
        logic                fill;
        logic [WAY_W-1:0]    way;
        logic [MAX_WAYS-1:0] in_use;
    } lsac_touch_t;

endpackage

### rtl/lsac_tag_ram.sv
module lsac_tag_ram #(
    parameter int AW = 9,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [1 << AW];
    logic [DW-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/lsac_row_update.sv
module lsac_row_update
    import lsac_pkg::*;
(
    input  lsac_row_t   row,
    input  lsac_touch_t ctl,
    output lsac_row_t   row_new
);

    logic [RANK_W:0] old_rank;

    // A fill ages every other valid line in use; a hit ages only lines younger than it
    always_comb
    begin
        old_rank = ctl.fill ? (RANK_W+1)'(1 << RANK_W) : {1'b0, row.rank[ctl.way]};
        row_new  = row;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            if (ctl.in_use[i] && (WAY_W'(i) != ctl.way) && row.valid[i] &&
                ({1'b0, row.rank[i]} < old_rank) && (row.rank[i] != RANK_MAX))
            begin
                row_new.rank[i] = row.rank[i] + RANK_W'(1);
            end
        end
        row_new.rank[ctl.way] = '0;
        if (ctl.fill)
        begin
            row_new.valid[ctl.way] = 1'b1;
        end
    end

endmodule

### rtl/lru_set_assoc_cache_sim_unit.sv
// Channel  Signals                        Direction  Moves
// in       in_valid/in_ready, in_data     into block one access per transfer
// out      out_valid/out_ready, out_data  out        one result per load/store/modify
// cfg      cfg_we, cfg_index, cfg_data    into block one register write per cycle
//
// A data access goes through the meta, search and update states. The search visits
// the ways in use in order up to a hit: one tag compare per cycle on the single
// read port of the tag RAM. An instruction fetch is dropped with no result.
// Reset clears all lines (per-set valid flags) and the totals, and loads the reset configuration.
// A result waits in an output register; only the write-back of the following
// access stalls while out_ready is low.
module lru_set_assoc_cache_sim_unit
    import lsac_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lsac_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output lsac_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_META   = 2'd1;
    localparam logic [1:0] S_SEARCH = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    // Control registers
    logic [1:0]          state_reg, state_next;
    logic [2:0]          set_bits_reg;
    logic [4:0]          block_bits_reg;
    logic [3:0]          num_ways_reg;
    logic [NUM_SETS-1:0] row_ok_reg;
    logic                row_ok_q_reg;
    logic                out_valid_reg;
    logic [SUM_W-1:0]    hit_sum_reg, hit_sum_next;
    logic [SUM_W-1:0]    miss_sum_reg, miss_sum_next;
    logic [SUM_W-1:0]    evict_sum_reg, evict_sum_next;

    // Per-access working registers
    logic [MAX_SET_BITS-1:0] set_reg, set_next;
    logic [TAG_W-1:0]        tag_reg, tag_next;
    logic                    modify_reg, modify_next;
    logic [WAY_W-1:0]        ways_m1_reg, ways_m1_next;
    logic [WAY_W-1:0]        way_reg, way_next;
    logic                    inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]        inv_way_reg, inv_way_next;
    logic [RANK_W-1:0]       best_rank_reg, best_rank_next;
    logic [WAY_W-1:0]        best_way_reg, best_way_next;
    logic                    hit_reg, hit_next;
    logic                    evict_reg, evict_next;
    logic [WAY_W-1:0]        pick_reg, pick_next;
    lsac_out_t               out_data_reg;
    lsac_out_t               out_data_next;

    // Row memory of valid bits and ranks
    lsac_row_t meta_mem [NUM_SETS];
    lsac_row_t meta_q_reg;
    lsac_row_t row_eff;
    lsac_row_t row_new;
    lsac_touch_t touch;

    // Address split
    logic [2:0]          set_bits_eff;
    logic [5:0]          split_sum;
    logic [MAX_SET_BITS-1:0] addr_sh;
    logic [MAX_SET_BITS-1:0] set_mask;

    // Search datapath
    logic [TAG_W-1:0]   tag_q;
    logic [LINE_AW-1:0] tag_raddr;
    logic               tag_we;
    logic               cur_valid;
    logic [RANK_W-1:0]  cur_rank;
    logic               cur_match;
    logic               last_way;
    logic               write_back;
    logic               start;
    logic [1:0]         hits_now;
    logic [SUM_W:0]     hit_add, miss_add, evict_add;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Address split into set index and tag
    assign set_bits_eff = (set_bits_reg > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_reg;
    assign split_sum    = 6'(set_bits_eff) + 6'(block_bits_reg);
    assign addr_sh      = MAX_SET_BITS'(in_data.address >> block_bits_reg);
    assign set_mask     = ~({MAX_SET_BITS{1'b1}} << set_bits_eff);

    // Tag store, one way read per cycle
    assign tag_raddr = (state_reg == S_SEARCH) ? {set_reg, way_reg + WAY_W'(1)}
                                               : {set_reg, {WAY_W{1'b0}}};
    assign tag_we    = write_back && !hit_reg;

    lsac_tag_ram #(
        .AW (LINE_AW),
        .DW (TAG_W)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr ({set_reg, pick_reg}),
        .wdata (tag_reg),
        .raddr (tag_raddr),
        .rdata (tag_q)
    );

    // Set row memory, registered read
    always_ff @(posedge clk)
    begin
        if (write_back)
        begin
            meta_mem[set_reg] <= row_new;
        end
        meta_q_reg <= meta_mem[set_reg];
    end

    // A set never written since reset reads as all invalid
    assign row_eff = row_ok_q_reg ? meta_q_reg : '0;

    // Compare of the visited way
    assign cur_valid = row_eff.valid[way_reg];
    assign cur_rank  = row_eff.rank[way_reg];
    assign cur_match = cur_valid && (tag_q == tag_reg);
    assign last_way  = (way_reg == ways_m1_reg);

    // LRU update of the row
    always_comb
    begin
        touch.fill = !hit_reg;
        touch.way  = pick_reg;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            touch.in_use[i] = (WAY_W'(i) <= ways_m1_reg);
        end
    end

    lsac_row_update u_row_update (
        .row     (row_eff),
        .ctl     (touch),
        .row_new (row_new)
    );

    assign write_back = (state_reg == S_UPDATE) && (!out_valid_reg || out_ready);

    // Hits of this access: a modify adds a second, always hitting, access
    assign hits_now = 2'(hit_reg) + 2'(modify_reg);

    // Saturating totals
    assign hit_add   = {1'b0, hit_sum_reg} + (SUM_W+1)'(hits_now);
    assign miss_add  = {1'b0, miss_sum_reg} + (SUM_W+1)'(!hit_reg);
    assign evict_add = {1'b0, evict_sum_reg} + (SUM_W+1)'(evict_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        modify_next    = modify_reg;
        ways_m1_next   = ways_m1_reg;
        way_next       = way_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        best_rank_next = best_rank_reg;
        best_way_next  = best_way_reg;
        hit_next       = hit_reg;
        evict_next     = evict_reg;
        pick_next      = pick_reg;
        hit_sum_next   = hit_sum_reg;
        miss_sum_next  = miss_sum_reg;
        evict_sum_next = evict_sum_reg;
        out_data_next  = out_data_reg;
        start          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.access_kind)
                        KIND_LOAD, KIND_STORE, KIND_MODIFY: start = 1'b1;
                        KIND_IFETCH:                        start = 1'b0;
                        default:                            start = 1'b0;
                    endcase
                end
                if (start)
                begin
                    set_next    = addr_sh & set_mask;
                    tag_next    = split_sum[5] ? '0 : (in_data.address >> split_sum[4:0]);
                    modify_next = (in_data.access_kind == KIND_MODIFY);
                    if (num_ways_reg == 4'd0)
                    begin
                        ways_m1_next = '0;
                    end
                    else if (num_ways_reg > 4'(MAX_WAYS))
                    begin
                        ways_m1_next = WAY_W'(MAX_WAYS - 1);
                    end
                    else
                    begin
                        ways_m1_next = WAY_W'(num_ways_reg - 4'd1);
                    end
                    way_next       = '0;
                    inv_found_next = 1'b0;
                    inv_way_next   = '0;
                    best_rank_next = '0;
                    best_way_next  = '0;
                    state_next     = S_META;
                end
            end

            S_META:
            begin
                state_next = S_SEARCH;
            end

            S_SEARCH:
            begin
                // Track the lowest invalid way and the oldest way as we go
                if (!inv_found_reg && !cur_valid)
                begin
                    inv_found_next = 1'b1;
                    inv_way_next   = way_reg;
                end
                if (cur_rank > best_rank_reg)
                begin
                    best_rank_next = cur_rank;
                    best_way_next  = way_reg;
                end
                if (cur_match)
                begin
                    hit_next   = 1'b1;
                    evict_next = 1'b0;
                    pick_next  = way_reg;
                    state_next = S_UPDATE;
                end
                else if (last_way)
                begin
                    hit_next   = 1'b0;
                    evict_next = !inv_found_next;
                    pick_next  = inv_found_next ? inv_way_next : best_way_next;
                    state_next = S_UPDATE;
                end
                else
                begin
                    way_next = way_reg + WAY_W'(1);
                end
            end

            S_UPDATE:
            begin
                if (write_back)
                begin
                    hit_sum_next   = hit_add[SUM_W] ? '1 : hit_add[SUM_W-1:0];
                    miss_sum_next  = miss_add[SUM_W] ? '1 : miss_add[SUM_W-1:0];
                    evict_sum_next = evict_add[SUM_W] ? '1 : evict_add[SUM_W-1:0];
                    out_data_next.hit_count       = hits_now;
                    out_data_next.was_miss        = !hit_reg;
                    out_data_next.was_eviction    = evict_reg;
                    out_data_next.total_hits      = hit_sum_next;
                    out_data_next.total_misses    = miss_sum_next;
                    out_data_next.total_evictions = evict_sum_next;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            num_ways_reg   <= NUM_WAYS_RST;
            row_ok_reg     <= '0;
            row_ok_q_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_sum_reg    <= '0;
            miss_sum_reg   <= '0;
            evict_sum_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            hit_sum_reg   <= hit_sum_next;
            miss_sum_reg  <= miss_sum_next;
            evict_sum_reg <= evict_sum_next;
            row_ok_q_reg  <= row_ok_reg[set_reg];
            if (write_back)
            begin
                row_ok_reg[set_reg] <= 1'b1;
            end
            if (write_back)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                    CFG_BLOCK_BITS: block_bits_reg <= cfg_data;
                    CFG_NUM_WAYS:   num_ways_reg   <= cfg_data[3:0];
                    default:        ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        set_reg       <= set_next;
        tag_reg       <= tag_next;
        modify_reg    <= modify_next;
        ways_m1_reg   <= ways_m1_next;
        way_reg       <= way_next;
        inv_found_reg <= inv_found_next;
        inv_way_reg   <= inv_way_next;
        best_rank_reg <= best_rank_next;
        best_way_reg  <= best_way_next;
        hit_reg       <= hit_next;
        evict_reg     <= evict_next;
        pick_reg      <= pick_next;
        out_data_reg  <= out_data_next;
    end

endmodule

### rtl/lsac_checker.sv
module lsac_checker
    import lsac_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input lsac_in_t             in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input lsac_out_t            out_data
);

    // A held result stays put until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A data access keeps the block busy in the following cycle
    a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.access_kind != KIND_IFETCH) |=> !in_ready)
        else $error("block ready right after a data access");

    // An instruction fetch is dropped at once
    a_ifetch_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_data.access_kind == KIND_IFETCH) |=> in_ready)
        else $error("instruction fetch stalled the block");

    // Hit, miss and eviction flags agree with each other
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.hit_count != 2'd3) &&
                      !(out_data.was_eviction && !out_data.was_miss) &&
                      !(out_data.was_miss && (out_data.hit_count == 2'd2)) &&
                      !(!out_data.was_miss && (out_data.hit_count == 2'd0)))
        else $error("inconsistent result flags");

endmodule

bind lru_set_assoc_cache_sim_unit lsac_checker u_lsac_checker (.*);

### dv/tb_lru_set_assoc_cache_sim_unit.sv
module tb_lru_set_assoc_cache_sim_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lsac_pkg::*;

    localparam int IDLE_LIMIT  = 2000;  // cycles with no transfer before giving up
    localparam int SETTLE_CYC  = 20;    // settle time, longer than the longest unstalled access
    localparam int RAND_PHASES = 14;
    localparam int PHASE_ITEMS = 105;   // loads/stores/modifies per random phase

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    lsac_in_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    lsac_out_t out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DW-1:0]    cfg_data  = '0;

    lru_set_assoc_cache_sim_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Shadow copy of the cache contents and settings
    logic [TAG_W-1:0]  cache_tag [NUM_SETS*MAX_WAYS];
    logic              cache_vld [NUM_SETS*MAX_WAYS];
    logic [RANK_W-1:0] cache_age [NUM_SETS*MAX_WAYS];
    logic [SUM_W-1:0]  sum_hits;
    logic [SUM_W-1:0]  sum_misses;
    logic [SUM_W-1:0]  sum_evicts;
    logic [2:0]        cur_set_bits;
    logic [4:0]        cur_block_bits;
    logic [3:0]        cur_ways;

    lsac_in_t  access_q[$];        // accesses waiting to be driven
    lsac_out_t access_stats_q[$];  // predicted results, oldest first

    int  mismatches = 0;
    int  results_seen = 0;
    int  send_gap = 0;
    int  recv_stall = 0;
    int  nxt_stall;
    int  stuck_cycles = 0;
    bit  in_idle_on = 1'b1;
    bit  out_idle_on = 1'b1;

    function automatic int draw_wait(input bit enable);
        return enable ? int'($urandom_range(0, 6)) : 0;
    endfunction

    function automatic int active_ways();
        if (cur_ways == 0)
            return 1;
        if (cur_ways > MAX_WAYS)
            return MAX_WAYS;
        return int'(cur_ways);
    endfunction

    function automatic int active_set_bits();
        return (cur_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
    endfunction

    function automatic logic [SUM_W-1:0] sat_inc(input logic [SUM_W-1:0] v, input int n);
        longint unsigned s;
        s = longint'(v) + n;
        return (s > 64'hFFFF_FFFF) ? '1 : s[SUM_W-1:0];
    endfunction

    // Move way w to most recent; valid lines younger than its old rank age by one
    function automatic void promote(input int base, input int ways, input int w,
                                    input int old_rank);
        int e;
        for (int i = 0; i < ways; i++)
        begin
            e = base + i;
            if (i != w && cache_vld[e] && cache_age[e] < old_rank && cache_age[e] < RANK_MAX)
                cache_age[e] = cache_age[e] + 1'b1;
        end
        cache_age[base + w] = '0;
    endfunction

    // One lookup; returns 1 on hit, otherwise fills a way and flags a replacement if the set was full
    function automatic bit lookup_fill(input int set_idx, input logic [TAG_W-1:0] tag,
                                       output bit evicted);
        int ways;
        int base;
        int pick;
        int best;
        ways    = active_ways();
        base    = set_idx * MAX_WAYS;
        pick    = ways;
        best    = 0;
        evicted = 1'b0;
        for (int i = 0; i < ways; i++)
        begin
            if (cache_vld[base + i] && cache_tag[base + i] == tag)
            begin
                promote(base, ways, i, int'(cache_age[base + i]));
                return 1'b1;
            end
        end
        for (int i = 0; i < ways; i++)
        begin
            if (!cache_vld[base + i])
            begin
                pick = i;
                break;
            end
        end
        // Set full: oldest in-use way goes, lowest way on a tie
        if (pick == ways)
        begin
            pick = 0;
            for (int i = 0; i < ways; i++)
            begin
                if (cache_age[base + i] > best)
                begin
                    best = int'(cache_age[base + i]);
                    pick = i;
                end
            end
            evicted = 1'b1;
            cache_vld[base + pick] = 1'b0;
        end
        cache_tag[base + pick] = tag;
        cache_vld[base + pick] = 1'b1;
        promote(base, ways, pick, int'(RANK_MAX) + 1);
        return 1'b0;
    endfunction

    function automatic void predict_access_stats(input lsac_in_t acc);
        int               s;
        int               b;
        longint unsigned  sh;
        int               set_idx;
        logic [TAG_W-1:0] tag;
        bit               ev;
        bit               ev2;
        int               hits;
        bit               miss;
        bit               evict;
        lsac_out_t        r;
        if (acc.access_kind == KIND_IFETCH)
            return;
        s       = active_set_bits();
        b       = int'(cur_block_bits);
        sh      = longint'(acc.address) >> b;
        sh      = sh & ((64'd1 << s) - 1);
        set_idx = int'(sh[MAX_SET_BITS-1:0]);
        sh      = longint'(acc.address) >> (s + b);
        tag     = (s + b >= 32) ? '0 : sh[TAG_W-1:0];
        hits    = 0;
        miss    = 1'b0;
        evict   = 1'b0;
        if (lookup_fill(set_idx, tag, ev))
            hits++;
        else
        begin
            miss  = 1'b1;
            evict = ev;
        end
        // Modify: second access to the same line
        if (acc.access_kind == KIND_MODIFY)
        begin
            if (lookup_fill(set_idx, tag, ev2))
                hits++;
        end
        sum_hits   = sat_inc(sum_hits, hits);
        sum_misses = sat_inc(sum_misses, miss);
        sum_evicts = sat_inc(sum_evicts, evict);
        r.hit_count       = hits[1:0];
        r.was_miss        = miss;
        r.was_eviction    = evict;
        r.total_hits      = sum_hits;
        r.total_misses    = sum_misses;
        r.total_evictions = sum_evicts;
        access_stats_q.push_back(r);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            report_mismatch($sformatf("%s expected 0x%0h got 0x%0h", name, want, got));
    endtask

    task automatic check_result(input lsac_out_t got);
        lsac_out_t want;
        if (access_stats_q.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result 0x%0h", got));
            return;
        end
        want = access_stats_q.pop_front();
        check_field("hit_count",    32'(want.hit_count),    32'(got.hit_count));
        check_field("was_miss",     32'(want.was_miss),     32'(got.was_miss));
        check_field("was_eviction", 32'(want.was_eviction), 32'(got.was_eviction));
        check_field("total_hits",      want.total_hits,      got.total_hits);
        check_field("total_misses",    want.total_misses,    got.total_misses);
        check_field("total_evictions", want.total_evictions, got.total_evictions);
    endtask

    // Driver: presents queued accesses, random gap after each one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_access_stats(in_data);
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (access_q.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= access_q.pop_front();
                    send_gap <= draw_wait(in_idle_on);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result transfer, random stall before the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            recv_stall <= 0;
        end
        else if (out_valid && out_ready)
        begin
            check_result(out_data);
            results_seen++;
            nxt_stall = draw_wait(out_idle_on);
            recv_stall <= nxt_stall;
            out_ready  <= (nxt_stall == 0);
        end
        else if (recv_stall != 0)
        begin
            // stall only counts down while a result is offered
            if (out_valid)
            begin
                recv_stall <= recv_stall - 1;
                out_ready  <= (recv_stall == 1);
            end
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            stuck_cycles <= 0;
        else if (stuck_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SET_BITS:   cur_set_bits   = val[2:0];
            CFG_BLOCK_BITS: cur_block_bits = val[4:0];
            CFG_NUM_WAYS:   cur_ways       = val[3:0];
            default:        ;
        endcase
    endtask

    task automatic queue_access(input logic [1:0] kind, input logic [31:0] addr);
        lsac_in_t t;
        t.access_kind = kind;
        t.address     = addr;
        access_q.push_back(t);
    endtask

    // Block is idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (access_q.size() != 0 || in_valid || access_stats_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // Mostly a small working set of lines in two sets, so hits and evictions are common
    task automatic load_random_phase(input int n_data);
        logic [31:0]     tag_pool [12];
        logic [5:0]      set_pool [2];
        int              pool_n;
        int              counted;
        int              s;
        int              b;
        logic [1:0]      kind;
        logic [31:0]     addr;
        longint unsigned t64;
        longint unsigned s64;
        longint unsigned o64;
        s      = active_set_bits();
        b      = int'(cur_block_bits);
        pool_n = active_ways() + $urandom_range(0, 3);
        for (int i = 0; i < pool_n; i++)
            tag_pool[i] = $urandom();
        for (int i = 0; i < 2; i++)
            set_pool[i] = 6'($urandom_range(0, NUM_SETS - 1));
        counted = 0;
        while (counted < n_data)
        begin
            kind = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 4) == 0)
                addr = $urandom();
            else
            begin
                t64  = 64'(tag_pool[$urandom_range(0, pool_n - 1)]);
                s64  = 64'(set_pool[$urandom_range(0, 1)]);
                o64  = 64'($urandom());
                t64  = (t64 << (s + b)) | ((s64 & ((64'd1 << s) - 1)) << b)
                     | (o64 & ((64'd1 << b) - 1));
                addr = t64[31:0];
            end
            queue_access(kind, addr);
            if (kind != KIND_IFETCH)
                counted++;
        end
    endtask

    // Stimulus
    initial
    begin
        logic [4:0] sb;
        logic [4:0] bb;
        logic [4:0] nw;

        cur_set_bits   = SET_BITS_RST;
        cur_block_bits = BLOCK_BITS_RST;
        cur_ways       = NUM_WAYS_RST;
        sum_hits       = '0;
        sum_misses     = '0;
        sum_evicts     = '0;
        for (int i = 0; i < NUM_SETS * MAX_WAYS; i++)
        begin
            cache_vld[i] = 1'b0;
            cache_age[i] = '0;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, direct mapped: hit, double hit, conflicts, fetch ignored
        @(negedge clk);
        queue_access(KIND_LOAD,   32'h0000_0000);
        queue_access(KIND_STORE,  32'h0000_000F);
        queue_access(KIND_MODIFY, 32'h0000_0004);
        queue_access(KIND_IFETCH, 32'h0000_0000);
        queue_access(KIND_MODIFY, 32'h0000_0100);
        queue_access(KIND_LOAD,   32'hFFFF_FFFF);
        queue_access(KIND_STORE,  32'hFFFF_FFF0);
        queue_access(KIND_LOAD,   32'h0000_00F0);
        queue_access(KIND_IFETCH, 32'hFFFF_FFFF);
        queue_access(KIND_STORE,  32'hAAAA_AAAA);
        queue_access(KIND_LOAD,   32'h5555_5555);
        queue_access(KIND_LOAD,   32'h0000_0000);
        wait_idle();

        // Two ways: LRU order decides the victim
        write_reg(CFG_NUM_WAYS, 5'd2);
        @(negedge clk);
        queue_access(KIND_LOAD,   32'h0000_0100);
        queue_access(KIND_LOAD,   32'h0000_0200);
        queue_access(KIND_STORE,  32'h0000_0100);
        queue_access(KIND_LOAD,   32'h0000_0300);
        queue_access(KIND_LOAD,   32'h0000_0200);
        queue_access(KIND_MODIFY, 32'h0000_0108);
        queue_access(KIND_LOAD,   32'h0000_0300);
        queue_access(KIND_IFETCH, 32'h0000_0300);
        queue_access(KIND_STORE,  32'h0000_0200);
        wait_idle();

        // Random phases; cache contents carry over between settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: begin sb = 5'd6; bb = 5'd26; nw = 5'd8;  end  // tag field empty
                1: begin sb = 5'd0; bb = 5'd0;  nw = 5'd15; end
                2: begin sb = 5'd7; bb = 5'd31; nw = 5'd0;  end
                3: begin sb = 5'd6; bb = 5'd0;  nw = 5'd8;  end
                4: begin sb = 5'd0; bb = 5'd26; nw = 5'd1;  end
                default:
                begin
                    sb = 5'($urandom_range(0, 31));
                    bb = 5'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                        : $urandom_range(0, 8));
                    nw = 5'($urandom_range(0, 31));
                end
            endcase
            write_reg(CFG_SET_BITS, sb);
            write_reg(CFG_BLOCK_BITS, bb);
            write_reg(CFG_NUM_WAYS, nw);
            @(negedge clk);
            in_idle_on  = ($urandom_range(0, 2) != 0);
            out_idle_on = ($urandom_range(0, 2) != 0);
            load_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
rtl/lsac_pkg.sv
rtl/lsac_tag_ram.sv
rtl/lsac_row_update.sv
rtl/lru_set_assoc_cache_sim_unit.sv
rtl/lsac_checker.sv
dv/tb_lru_set_assoc_cache_sim_unit.sv
